>>> rtl/svm_pkg.sv
// ----------------------------------------------------------------------------
// SVM package
// Shared constants, types and payload structs for the linear SVM block.
// ----------------------------------------------------------------------------
package svm_pkg;

  localparam int FEATURE_COUNT = 4;
  localparam int CLASS_COUNT   = 3;
  localparam int INPUT_FEATURES = 4;
  localparam int WEIGHT_COUNT  = FEATURE_COUNT * CLASS_COUNT;
  localparam int FW = (FEATURE_COUNT > 1) ? $clog2(FEATURE_COUNT) : 1;
  localparam int CW = (CLASS_COUNT > 1) ? $clog2(CLASS_COUNT) : 1;
  localparam int WW = (WEIGHT_COUNT > 1) ? $clog2(WEIGHT_COUNT) : 1;

  // Accumulator width for bias*2^8 + sum(w*x).
  localparam int ACC_W = 56;

  localparam logic [23:0] LR_INIT_RESET = 24'd16777;
  localparam logic [23:0] C_RESET       = 24'd655;
  localparam logic [15:0] DECAY_RESET   = 16'd65470;

  typedef enum logic [1:0] {
    OP_PREDICT = 2'd0,
    OP_TRAIN   = 2'd1,
    OP_EPOCH   = 2'd2,
    OP_CLEAR   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    CFG_LR_INIT = 2'd0,
    CFG_C       = 2'd1,
    CFG_DECAY   = 2'd2
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCORE,
    ST_DECIDE,
    ST_UPDATE,
    ST_STEP,
    ST_BIAS,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [1:0]         opcode;
    logic signed [15:0] feature_0;
    logic signed [15:0] feature_1;
    logic signed [15:0] feature_2;
    logic signed [15:0] feature_3;
    logic [1:0]         sample_class;
    logic [1:0]         trained_class;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         predicted_class;
    logic signed [39:0] best_score;
  } out_item_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic          load;      // capture the item
    logic          acc_init;  // load bias*2^8 for class cls
    logic          mac;       // add w[cls][feat]*x[feat]
    logic          compare;   // argmax step for the class just scored
    logic          dcalc;     // form the gradient term for feat of cls
    logic          upd;       // weight update for feat of cls
    logic          bias_upd;  // bias update
    logic          decay;     // lr decay
    logic          clear;     // zero model, reload lr
    logic          emit;      // strobe the result
    logic [CW-1:0] cls;
    logic [FW-1:0] feat;
  } cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic          violated;
  } stat_t;

  function automatic logic signed [15:0] feat_sel(input in_item_t it, input int f);
    logic signed [15:0] r;
    unique case (f)
      0: r = it.feature_0;
      1: r = it.feature_1;
      2: r = it.feature_2;
      3: r = it.feature_3;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

>>> rtl/svm_ctrl.sv
// ----------------------------------------------------------------------------
// SVM controller
// Sequences one operation through the datapath, one multiply per cycle.
// ----------------------------------------------------------------------------
module svm_ctrl import svm_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  op_t      op,
  input  logic     tc_valid,
  input  logic [CW-1:0] tc,
  input  stat_t    stat,
  output logic     busy,
  output cmd_t     cmd
);

  state_t        state, state_next;
  op_t           op_r;
  logic [CW-1:0] cls, cls_next;
  logic [FW:0]   feat, feat_next;   // runs to FEATURE_COUNT, one past the last
  logic          pend, pend_next;   // compare of the finished class pending

  // State and counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cls   <= '0;
      feat  <= '0;
      pend  <= 1'b0;
      op_r  <= OP_PREDICT;
    end else begin
      state <= state_next;
      cls   <= cls_next;
      feat  <= feat_next;
      pend  <= pend_next;
      if (start && !busy) op_r <= op;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    cls_next   = cls;
    feat_next  = feat;
    pend_next  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          feat_next = '0;
          priority if (op == OP_PREDICT) begin
            cls_next = '0; state_next = ST_SCORE;
          end else if (op == OP_TRAIN) begin
            cls_next = tc;
            state_next = tc_valid ? ST_SCORE : ST_IDLE;
          end else begin
            state_next = ST_DONE;
          end
        end
      end
      ST_SCORE: begin
        // feat == 0 means the bias load cycle; then one MAC per feature.
        if (feat == (FW+1)'(FEATURE_COUNT)) begin
          feat_next = '0;
          if (op_r == OP_TRAIN) begin
            state_next = ST_DECIDE;
          end else begin
            pend_next = 1'b1;
            if (cls == CW'(CLASS_COUNT - 1)) state_next = ST_DONE;
            else cls_next = cls + 1'b1;
          end
        end else begin
          feat_next = feat + 1'b1;
        end
      end
      ST_DECIDE: state_next = ST_UPDATE;
      // Each weight passes through two states: the gradient term, then the step.
      ST_UPDATE: state_next = ST_STEP;
      ST_STEP: begin
        if (feat == (FW+1)'(FEATURE_COUNT - 1)) begin
          feat_next = '0; state_next = ST_BIAS;
        end else begin
          feat_next = feat + 1'b1; state_next = ST_UPDATE;
        end
      end
      ST_BIAS: state_next = ST_IDLE;
      ST_DONE: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs.
  logic mac_phase;
  always_comb begin
    mac_phase    = (state == ST_SCORE) && (feat != '0);
    cmd          = '0;
    busy         = (state != ST_IDLE);
    cmd.load     = start && (state == ST_IDLE);
    cmd.cls      = cls;
    cmd.feat     = mac_phase ? FW'(feat - 1'b1) : FW'(feat);
    cmd.acc_init = (state == ST_SCORE) && (feat == '0);
    cmd.mac      = mac_phase;
    cmd.compare  = pend;
    cmd.dcalc    = (state == ST_UPDATE);
    cmd.upd      = (state == ST_STEP);
    cmd.bias_upd = (state == ST_BIAS) && stat.violated;
    cmd.decay    = (state == ST_DONE) && (op_r == OP_EPOCH);
    cmd.clear    = (state == ST_DONE) && (op_r == OP_CLEAR);
    cmd.emit     = (state == ST_DONE) && (op_r == OP_PREDICT);
  end

  // The last compare of a predict lands in the cycle that strobes the result.
  assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> $past(pend_next) || pend)
    else $error("result strobed without a final compare");
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_UPDATE) |-> (op_r == OP_TRAIN))
    else $error("weight update outside a train step");
  assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> !$past(cmd.load))
    else $error("busy dropped in the load cycle");

endmodule

>>> rtl/svm_dp.sv
// ----------------------------------------------------------------------------
// SVM datapath
// Model storage, configuration registers and the multipliers.
// ----------------------------------------------------------------------------
module svm_dp import svm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_data,
  input  in_item_t    item,
  input  cmd_t        cmd,
  output stat_t       stat,
  output logic        result_valid,
  output out_item_t   result
);

  logic [23:0] lr_init, c_reg, learn_rate;
  logic [15:0] decay;
  logic signed [31:0] wt [WEIGHT_COUNT];
  logic signed [31:0] bt [CLASS_COUNT];
  in_item_t     it;
  logic signed [ACC_W-1:0] acc, best_acc;
  logic [CW-1:0] best_cls;
  logic          have_best;
  logic          violated;
  logic          y_pos;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      lr_init <= LR_INIT_RESET;
      c_reg   <= C_RESET;
      decay   <= DECAY_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_LR_INIT: lr_init <= cfg_data;
        CFG_C:       c_reg   <= cfg_data;
        CFG_DECAY:   decay   <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Selected weight, feature and their product.
  logic [WW-1:0] widx;
  logic signed [31:0] w_sel;
  logic signed [15:0] x_sel;
  logic signed [47:0] wx;
  always_comb begin
    widx  = WW'(cmd.cls * FEATURE_COUNT + cmd.feat);
    w_sel = wt[widx];
    x_sel = feat_sel(it, int'(cmd.feat));
    wx    = w_sel * x_sel;
  end

  // Weight update, first cycle: d = [y*x*2^28] - C*w, Q.36, reduced to Q.20.
  logic signed [56:0] cw, d36;
  logic signed [40:0] d20;
  logic signed [39:0] dsat, dsat_r;
  always_comb begin
    cw  = $signed({1'b0, c_reg}) * w_sel;
    d36 = -cw;
    if (violated)
      d36 = y_pos ? d36 + (57'(x_sel) <<< 28) : d36 - (57'(x_sel) <<< 28);
    d20 = 41'(d36 >>> 16);
    if (d20 > 41'sh7F_FFFF_FFFF)       dsat = 40'sh7F_FFFF_FFFF;
    else if (d20 < -41'sh80_0000_0000) dsat = -40'sh80_0000_0000;
    else                               dsat = d20[39:0];
  end

  // The saturated gradient term is held for the step cycle.
  always_ff @(posedge clk) begin
    if (cmd.dcalc) dsat_r <= dsat;
  end

  // Weight update, second cycle: w += floor(lr*d / 2^24), saturated.
  logic signed [64:0] step_full;
  logic signed [40:0] step;
  logic signed [41:0] wsum;
  logic signed [31:0] wnew;
  always_comb begin
    step_full = $signed({1'b0, learn_rate}) * dsat_r;
    step = 41'(step_full >>> 24);
    wsum = 42'(w_sel) + 42'(step);
    if (wsum > 42'sh7FFF_FFFF)       wnew = 32'sh7FFF_FFFF;
    else if (wsum < -42'sh8000_0000) wnew = -32'sh8000_0000;
    else                             wnew = wsum[31:0];
  end

  // Bias update: b += floor(+-lr / 16).
  logic signed [33:0] bsum;
  logic signed [31:0] bnew;
  logic signed [24:0] lr_s;
  always_comb begin
    lr_s = $signed({1'b0, learn_rate});
    bsum = 34'(bt[cmd.cls]) + (y_pos ? 34'(lr_s >>> 4) : 34'((-lr_s) >>> 4));
    if (bsum > 34'sh7FFF_FFFF)       bnew = 32'sh7FFF_FFFF;
    else if (bsum < -34'sh8000_0000) bnew = -32'sh8000_0000;
    else                             bnew = bsum[31:0];
  end

  // Learning rate decay product.
  logic [39:0] lr_dec;
  assign lr_dec = learn_rate * decay;

  // Model state. Reset loads the reset rate directly, since lr_init is
  // itself being reset in the same cycle.
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      for (int i = 0; i < WEIGHT_COUNT; i++) wt[i] <= '0;
      for (int i = 0; i < CLASS_COUNT; i++)  bt[i] <= '0;
      learn_rate <= rst ? LR_INIT_RESET : lr_init;
    end else begin
      if (cmd.upd)      wt[widx] <= wnew;
      if (cmd.bias_upd) bt[cmd.cls] <= bnew;
      if (cmd.decay)    learn_rate <= lr_dec[39:16];
    end
  end

  // Item capture, accumulator and argmax. A compare normally arrives while
  // the next class is loading; the final one arrives with the result strobe,
  // when the class count has not moved on.
  logic signed [ACC_W-1:0] acc_cur;
  assign acc_cur = acc;
  always_ff @(posedge clk) begin
    if (rst) begin
      have_best    <= 1'b0;
      result_valid <= 1'b0;
      violated     <= 1'b0;
    end else begin
      result_valid <= cmd.emit;
      if (cmd.load) begin
        it        <= item;
        have_best <= 1'b0;
        y_pos     <= (item.sample_class == item.trained_class);
      end
      if (cmd.acc_init) acc <= ACC_W'(bt[cmd.cls]) <<< 8;
      else if (cmd.mac) acc <= acc + ACC_W'(wx);
      if (cmd.compare && (!have_best || acc_cur > best_acc)) begin
        best_acc <= acc_cur;
        best_cls <= cmd.emit ? cmd.cls : CW'(cmd.cls - 1'b1);
      end
      if (cmd.compare) have_best <= 1'b1;
      if (!cmd.acc_init && !cmd.mac && !cmd.compare && !cmd.upd)
        violated <= y_pos ? (acc < (ACC_W'(1) <<< 28)) : (-acc < (ACC_W'(1) <<< 28));
    end
  end

  // Result: floor(best/256) saturated to 40 bits.
  logic signed [ACC_W-9:0] sc;
  always_comb begin
    sc = best_acc[ACC_W-1:8];
    result.predicted_class = best_cls;
    if (sc > (ACC_W-8)'(40'sh7F_FFFF_FFFF))       result.best_score = 40'sh7F_FFFF_FFFF;
    else if (sc < -(ACC_W-8)'(41'sh80_0000_0000)) result.best_score = -40'sh80_0000_0000;
    else                                          result.best_score = sc[39:0];
    stat.violated = violated;
  end

  assert property (@(posedge clk) disable iff (rst)
    cmd.upd |-> !cmd.mac && !cmd.acc_init)
    else $error("update overlaps scoring");
  assert property (@(posedge clk) disable iff (rst)
    result_valid |-> have_best)
    else $error("result without a scored class");
  assert property (@(posedge clk) disable iff (rst)
    cmd.decay |=> learn_rate == $past(lr_dec[39:16]))
    else $error("decay not applied");

endmodule

>>> rtl/linear_svm_sgd_train_and_classify.sv
// ----------------------------------------------------------------------------
// Linear SVM, SGD training and one-vs-rest classification
// Top level: joins the controller and the datapath.
// ----------------------------------------------------------------------------
//  channel   handshake               payload
//  input     start & !busy           in_data (in_item_t)
//  result    result_valid, 1 cycle   result  (out_item_t)
//  config    cfg_valid & cfg_ready   cfg_index, cfg_data
//
// Predict: each class in turn takes a bias load and one MAC per feature on the
// single shared scoring multiplier, one product per cycle. Train: two
// multiplies per weight in separate cycles; a train step on a class beyond the
// last is accepted and leaves the block idle. Epoch end and clear pass through
// the done state. Synchronous reset clears the model at once. The receiver
// cannot stall; cfg_ready is always high.
module linear_svm_sgd_train_and_classify import svm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  in_item_t    in_data,
  output logic        result_valid,
  output out_item_t   result,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_data
);

  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready = 1'b1;

  svm_ctrl u_ctrl (
    .clk, .rst, .start,
    .op       (op_t'(in_data.opcode)),
    .tc_valid (in_data.trained_class < 2'(CLASS_COUNT)),
    .tc       (CW'(in_data.trained_class)),
    .stat, .busy, .cmd
  );

  svm_dp u_dp (
    .clk, .rst, .cfg_valid, .cfg_index, .cfg_data,
    .item (in_data), .cmd, .stat, .result_valid, .result
  );

endmodule

>>> tb/linear_svm_sgd_train_and_classify_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Linear SVM block testbench
// Sends predict, train, epoch-end and clear commands to the block. A local
// fixed-point model of the one-vs-rest SVM predicts each classification, and
// a checker compares every result strobe against the oldest prediction.
// ----------------------------------------------------------------------------
module linear_svm_sgd_train_and_classify_tb;
  import svm_pkg::*;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  in_item_t    in_data;
  logic        result_valid;
  out_item_t   result;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [23:0] cfg_data;

  linear_svm_sgd_train_and_classify DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .in_data(in_data),
    .result_valid(result_valid), .result(result), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  localparam int STALL_LIMIT = 20000;

  // Local copy of the model state and the registers.
  logic signed [31:0] model_w [WEIGHT_COUNT];
  logic signed [31:0] model_b [CLASS_COUNT];
  logic [23:0]        model_lr;
  logic [23:0]        lr_init_reg;
  logic [23:0]        c_reg;
  logic [15:0]        decay_reg;

  out_item_t expected_scores[$];
  int        errors;
  int        idle_cycles;
  bit        calm;

  always #5 clk = ~clk;

  function automatic longint sat_to(longint v, int bits);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (bits - 1)) - 1;
    lo = -hi - 1;
    return (v > hi) ? hi : ((v < lo) ? lo : v);
  endfunction

  function automatic longint feat_val(in_item_t it, int f);
    case (f)
      0: return longint'(it.feature_0);
      1: return longint'(it.feature_1);
      2: return longint'(it.feature_2);
      3: return longint'(it.feature_3);
      default: return 0;
    endcase
  endfunction

  function automatic longint class_sum(in_item_t it, int c);
    longint acc;
    acc = longint'(model_b[c]) * 256;
    for (int f = 0; f < FEATURE_COUNT; f++)
      acc += longint'(model_w[c * FEATURE_COUNT + f]) * feat_val(it, f);
    return acc;
  endfunction

  function automatic void reset_model();
    for (int i = 0; i < WEIGHT_COUNT; i++) model_w[i] = '0;
    for (int c = 0; c < CLASS_COUNT; c++) model_b[c] = '0;
    model_lr = lr_init_reg;
  endfunction

  // Advance the model by one command and queue a score where one is due.
  function automatic void svm_apply(in_item_t it);
    longint    acc;
    longint    best_acc;
    longint    y;
    longint    w;
    longint    d;
    longint    stp;
    int        best;
    int        tc;
    bit        viol;
    out_item_t o;
    case (op_t'(it.opcode))
      OP_PREDICT: begin
        best = 0;
        best_acc = class_sum(it, 0);
        for (int c = 1; c < CLASS_COUNT; c++) begin
          acc = class_sum(it, c);
          if (acc > best_acc) begin
            best_acc = acc;
            best = c;
          end
        end
        o.predicted_class = best[1:0];
        o.best_score = 40'(sat_to(best_acc >>> 8, 40));
        expected_scores.push_back(o);
      end
      OP_TRAIN: begin
        tc = it.trained_class;
        if (tc < CLASS_COUNT) begin
          y = (it.sample_class == it.trained_class) ? 1 : -1;
          acc = class_sum(it, tc);
          viol = (y * acc) < (longint'(1) <<< 28);
          for (int f = 0; f < FEATURE_COUNT; f++) begin
            w = model_w[tc * FEATURE_COUNT + f];
            d = -(longint'(c_reg) * w);
            if (viol) d += y * feat_val(it, f) * (longint'(1) <<< 28);
            d = sat_to(d >>> 16, 40);
            stp = (longint'(model_lr) * d) >>> 24;
            model_w[tc * FEATURE_COUNT + f] = 32'(sat_to(w + stp, 32));
          end
          if (viol)
            model_b[tc] = 32'(sat_to(longint'(model_b[tc]) +
                                     ((y * longint'(model_lr)) >>> 4), 32));
        end
      end
      OP_EPOCH: model_lr = 24'((longint'(model_lr) * longint'(decay_reg)) >> 16);
      default: reset_model();
    endcase
  endfunction

  // Result checker: the block strobes each score for one cycle.
  always @(posedge clk) begin
    if (!rst && result_valid) begin
      if (expected_scores.size() == 0) begin
        $display("%0t: unexpected result class=%0d score=%0d", $time,
                 result.predicted_class, result.best_score);
        errors++;
      end else begin
        automatic out_item_t e = expected_scores.pop_front();
        if (e.predicted_class !== result.predicted_class) begin
          $display("%0t: class mismatch expected %0d actual %0d", $time,
                   e.predicted_class, result.predicted_class);
          errors++;
        end
        if (e.best_score !== result.best_score) begin
          $display("%0t: score mismatch expected %0d actual %0d", $time,
                   e.best_score, result.best_score);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles with no beat accepted.
  always @(posedge clk) begin
    if ((start && !busy) || result_valid || (cfg_valid && cfg_ready) || rst)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("linear_svm_sgd_train_and_classify_tb: FAIL");
      $finish;
    end
  end

  // Send one command, with a random gap before it unless in a calm stretch.
  // Start stays high after the beat so that the next command can follow at
  // once; a gap or the drain lowers it.
  task automatic send_cmd(in_item_t it);
    if (!calm) begin
      while ($urandom_range(99) < 25) begin
        start <= 1'b0;
        @(posedge clk);
      end
    end
    start   <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    svm_apply(it);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [23:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_LR_INIT: lr_init_reg = val;
      CFG_C:       c_reg = val;
      default:     decay_reg = val[15:0];
    endcase
    @(posedge clk);
  endtask

  // Let every outstanding score arrive, then let the block settle.
  task automatic drain();
    start <= 1'b0;
    while (expected_scores.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  function automatic in_item_t make_cmd(op_t op, logic [15:0] f0, logic [15:0] f1,
                                        logic [15:0] f2, logic [15:0] f3,
                                        logic [1:0] sc, logic [1:0] tc);
    in_item_t it;
    it.opcode = op;
    it.feature_0 = f0;
    it.feature_1 = f1;
    it.feature_2 = f2;
    it.feature_3 = f3;
    it.sample_class = sc;
    it.trained_class = tc;
    return it;
  endfunction

  function automatic in_item_t rand_cmd(op_t op);
    return make_cmd(op, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                    2'($urandom_range(3)), 2'($urandom_range(3)));
  endfunction

  // Directed: field extremes, every operation, ties, out-of-range classes.
  task automatic test_directed();
    send_cmd(make_cmd(OP_PREDICT, 0, 0, 0, 0, 0, 0));
    send_cmd(make_cmd(OP_TRAIN, 16'h7FFF, 16'h8000, 16'h0100, 16'hFF00, 1, 1));
    send_cmd(make_cmd(OP_TRAIN, 16'h8000, 16'h7FFF, 16'hFFFF, 16'h0001, 0, 1));
    send_cmd(make_cmd(OP_TRAIN, 16'h0100, 16'h0100, 16'h0100, 16'h0100, 2, 2));
    send_cmd(make_cmd(OP_TRAIN, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 3, 0));
    send_cmd(make_cmd(OP_TRAIN, 16'h1234, 16'h4321, 16'h7FFF, 16'h8000, 1, 3));
    send_cmd(make_cmd(OP_PREDICT, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 0, 0));
    send_cmd(make_cmd(OP_PREDICT, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 3, 3));
    send_cmd(make_cmd(OP_PREDICT, 16'hFFFF, 16'h0001, 16'h8000, 16'h7FFF, 0, 0));
    send_cmd(make_cmd(OP_EPOCH, 0, 0, 0, 0, 0, 0));
    send_cmd(make_cmd(OP_PREDICT, 16'h0100, 0, 0, 0, 0, 0));
    send_cmd(make_cmd(OP_CLEAR, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 3, 3));
    send_cmd(make_cmd(OP_PREDICT, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 0, 0));
    drain();
  endtask

  // Well-formed training epochs with random samples and occasional noise.
  task automatic test_training(int n);
    in_item_t it;
    for (int i = 0; i < n; i++) begin
      calm = (i >= n / 3) && (i < n / 2);
      it = rand_cmd(OP_TRAIN);
      case ($urandom_range(19))
        0:        it.opcode = OP_EPOCH;
        1:        it.opcode = ($urandom_range(3) == 0) ? OP_CLEAR : OP_EPOCH;
        2, 3, 4:  it.opcode = OP_PREDICT;
        5:        it.opcode = 2'($urandom_range(3));
        default: begin
          it.sample_class = 2'($urandom_range(2));
          it.trained_class = 2'($urandom_range(2));
          if ($urandom_range(1)) begin
            it.feature_0 = 16'($urandom_range(1023) - 512);
            it.feature_1 = 16'($urandom_range(1023) - 512);
            it.feature_2 = 16'($urandom_range(1023) - 512);
            it.feature_3 = 16'($urandom_range(1023) - 512);
          end
        end
      endcase
      send_cmd(it);
    end
    calm = 0;
    drain();
  endtask

  // Register settings to sweep, extremes included.
  task automatic test_config_sweep();
    write_reg(CFG_LR_INIT, 24'hFFFFFF);
    write_reg(CFG_C, 24'd0);
    write_reg(CFG_DECAY, 24'h00FFFF);
    send_cmd(make_cmd(OP_CLEAR, 0, 0, 0, 0, 0, 0));
    test_training(250);
    write_reg(CFG_LR_INIT, 24'd0);
    write_reg(CFG_C, 24'hFFFFFF);
    write_reg(CFG_DECAY, 24'd0);
    test_training(100);
    send_cmd(make_cmd(OP_CLEAR, 0, 0, 0, 0, 0, 0));
    test_training(100);
    write_reg(CFG_LR_INIT, 24'($urandom_range(24'hFFFFFF)));
    write_reg(CFG_C, 24'($urandom_range(24'h03FFFF)));
    write_reg(CFG_DECAY, 24'($urandom_range(16'hFFFF)));
    send_cmd(make_cmd(OP_CLEAR, 0, 0, 0, 0, 0, 0));
    test_training(200);
  endtask

  initial begin
    clk = 0;
    rst = 1;
    start = 0;
    in_data = '0;
    cfg_valid = 0;
    cfg_index = CFG_LR_INIT;
    cfg_data = '0;
    errors = 0;
    calm = 0;
    lr_init_reg = LR_INIT_RESET;
    c_reg = C_RESET;
    decay_reg = DECAY_RESET;
    reset_model();
    repeat (12) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    test_directed();
    test_training(400);
    test_config_sweep();
    if (errors == 0)
      $display("linear_svm_sgd_train_and_classify_tb: PASS");
    else
      $display("linear_svm_sgd_train_and_classify_tb: FAIL");
    $finish;
  end

endmodule
